[src/tcc_pkg.sv]
// Package for the text console cursor engine: shared types, command codes,
// register indexes and fixed geometry constants.
// Used by every module of the block; depends on nothing.
package tcc_pkg;

    localparam int GLYPH_WIDTH    = 9;
    localparam int GLYPH_HEIGHT   = 16;
    localparam int TAB_STOP       = 4;
    localparam int WRAP_MARGIN_PX = 10;

    localparam int COL_W   = 10;
    localparam int PIX_W   = 14;
    localparam int SCR_W   = 13;
    localparam int COLOR_W = 32;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 96;
    localparam int CFG_ADDR_W = 3;

    localparam logic [COL_W-1:0] CUR_MAX = {COL_W{1'b1}};

    localparam logic [1:0] REQ_PRINT = 2'd0;
    localparam logic [1:0] REQ_MOVE  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic [7:0] CHAR_NUL   = 8'd0;
    localparam logic [7:0] CHAR_BS    = 8'd8;
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_SPACE = 8'd32;

    localparam logic [CFG_ADDR_W-1:0] REG_CHARS_PER_LINE   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CHARS_PER_COLUMN = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SCREEN_WIDTH_PX  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_LEFT_OFFSET_PX   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_TEXT_COLOUR      = 3'd4;

    typedef enum logic [1:0] {
        CMD_UPDATE = 2'd0,
        CMD_DRAW   = 2'd1,
        CMD_SCROLL = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [7:0]       char_code;
        logic [COL_W-1:0] move_col;
        logic [COL_W-1:0] move_row;
    } req_t;

    typedef struct packed {
        cmd_t               command;
        logic [7:0]         glyph;
        logic [PIX_W-1:0]   pixel_x;
        logic [PIX_W-1:0]   pixel_y;
        logic [COLOR_W-1:0] colour;
        logic [COL_W-1:0]   cursor_col;
        logic [COL_W-1:0]   cursor_row;
        logic               last;
    } res_t;

    typedef struct packed {
        logic [COL_W-1:0]   chars_per_line;
        logic [COL_W-1:0]   chars_per_column;
        logic [SCR_W-1:0]   screen_width_px;
        logic [7:0]         left_offset_px;
        logic [COLOR_W-1:0] text_colour;
    } cfg_t;

endpackage

[src/tcc_core.sv]
// Cursor logic of the text console cursor engine: turns one request and the
// current cursor into up to two result items and the next cursor.
// Depends on tcc_pkg.
module tcc_core (
    input  tcc_pkg::req_t              req,
    input  tcc_pkg::cfg_t              cfg,
    input  logic [tcc_pkg::COL_W-1:0]  cur_col,
    input  logic [tcc_pkg::COL_W-1:0]  cur_row,
    output logic [1:0]                 res_count,
    output tcc_pkg::res_t              res0,
    output tcc_pkg::res_t              res1,
    output logic [tcc_pkg::COL_W-1:0]  next_col,
    output logic [tcc_pkg::COL_W-1:0]  next_row
);
    import tcc_pkg::*;

    function automatic res_t make_res(
        input cmd_t               cmd,
        input logic [7:0]         glyph,
        input logic [COL_W-1:0]   pcol,
        input logic [COL_W-1:0]   prow,
        input logic [COL_W-1:0]   ccol,
        input logic [COL_W-1:0]   crow,
        input logic [7:0]         left,
        input logic [COLOR_W-1:0] colour
    );
        res_t r;
        r = '0;
        r.command    = cmd;
        r.cursor_col = ccol;
        r.cursor_row = crow;
        if (cmd == CMD_DRAW)
        begin
            r.glyph   = glyph;
            r.pixel_x = PIX_W'(PIX_W'(pcol) * PIX_W'(GLYPH_WIDTH)) + PIX_W'(left);
            r.pixel_y = PIX_W'(PIX_W'(prow) * PIX_W'(GLYPH_HEIGHT));
            r.colour  = colour;
        end
        return r;
    endfunction

    logic [COL_W-1:0] col_inc;
    logic [COL_W-1:0] row_inc;
    logic [PIX_W-1:0] col_px;
    logic             wrap_hit;
    logic             last_cell;
    logic [COL_W:0]   tab_col;
    logic [7:0]       ch;
    logic [7:0]       left;
    logic [COLOR_W-1:0] colour;

    assign ch      = req.char_code;
    assign left    = cfg.left_offset_px;
    assign colour  = cfg.text_colour;
    assign col_inc = (cur_col == CUR_MAX) ? CUR_MAX : cur_col + COL_W'(1);
    assign row_inc = (cur_row == CUR_MAX) ? CUR_MAX : cur_row + COL_W'(1);
    assign col_px  = PIX_W'(PIX_W'(cur_col) * PIX_W'(GLYPH_WIDTH));
    assign wrap_hit = (cfg.screen_width_px >= SCR_W'(WRAP_MARGIN_PX)) &&
        (col_px >= PIX_W'(cfg.screen_width_px) - PIX_W'(WRAP_MARGIN_PX));
    assign last_cell = (cur_row == cfg.chars_per_column) &&
        (cur_col == cfg.chars_per_line);
    // Tab stops are a power of two apart, so rounding down is a mask.
    assign tab_col = (COL_W+1)'(cur_col) + (COL_W+1)'(TAB_STOP) &
        ~(COL_W+1)'(TAB_STOP - 1);

    always_comb
    begin
        res_count = 2'd1;
        next_col  = cur_col;
        next_row  = cur_row;
        res0 = make_res(CMD_UPDATE, 8'd0, cur_col, cur_row, cur_col, cur_row, left, colour);
        res1 = res0;
        case (req.req_type)
            REQ_PRINT:
            begin
                if (ch == CHAR_NUL)
                begin
                    res_count = 2'd0;
                end
                else if (ch == CHAR_CR)
                begin
                    next_col = '0;
                    res0 = make_res(CMD_UPDATE, 8'd0, '0, cur_row, '0, cur_row, left, colour);
                end
                else if (ch == CHAR_BS)
                begin
                    if (cur_col != '0)
                    begin
                        next_col = cur_col - COL_W'(1);
                        res0 = make_res(CMD_DRAW, CHAR_SPACE, next_col, cur_row,
                                        next_col, cur_row, left, colour);
                    end
                    else if (cur_row != '0)
                    begin
                        next_col = cfg.chars_per_line - COL_W'(1);
                        next_row = cur_row - COL_W'(1);
                        res0 = make_res(CMD_DRAW, CHAR_SPACE, next_col, next_row,
                                        next_col, next_row, left, colour);
                    end
                end
                else if (last_cell)
                begin
                    res_count = 2'd2;
                    next_col  = '0;
                    res0 = make_res(CMD_SCROLL, 8'd0, '0, cur_row, '0, cur_row, left, colour);
                    if (ch == CHAR_LF || ch == CHAR_TAB)
                    begin
                        res1 = res0;
                    end
                    else
                    begin
                        next_col = COL_W'(1);
                        res1 = make_res(CMD_DRAW, ch, '0, cur_row, COL_W'(1), cur_row,
                                        left, colour);
                    end
                end
                else if (wrap_hit)
                begin
                    next_col = COL_W'(1);
                    next_row = row_inc;
                    res0 = make_res(CMD_DRAW, ch, '0, row_inc, COL_W'(1), row_inc,
                                    left, colour);
                end
                else if (ch == CHAR_LF || ch == CHAR_TAB)
                begin
                    if (ch == CHAR_TAB && tab_col < (COL_W+1)'(cfg.chars_per_line))
                    begin
                        next_col = tab_col[COL_W-1:0];
                        res0 = make_res(CMD_UPDATE, 8'd0, '0, '0, next_col, cur_row,
                                        left, colour);
                    end
                    else if (cur_row < cfg.chars_per_column)
                    begin
                        next_col = '0;
                        next_row = cur_row + COL_W'(1);
                        res0 = make_res(CMD_UPDATE, 8'd0, '0, '0, '0, next_row, left, colour);
                    end
                    else
                    begin
                        next_col = '0;
                        res0 = make_res(CMD_SCROLL, 8'd0, '0, '0, '0, cur_row, left, colour);
                    end
                end
                else
                begin
                    next_col = col_inc;
                    res0 = make_res(CMD_DRAW, ch, cur_col, cur_row, col_inc, cur_row,
                                    left, colour);
                end
            end
            REQ_MOVE:
            begin
                if (req.move_col <= cfg.chars_per_line && req.move_row <= cfg.chars_per_column)
                begin
                    next_col = req.move_col;
                    next_row = req.move_row;
                end
                res0 = make_res(CMD_UPDATE, 8'd0, '0, '0, next_col, next_row, left, colour);
            end
            REQ_CLEAR:
            begin
                next_col = '0;
                next_row = '0;
                res0 = make_res(CMD_CLEAR, 8'd0, '0, '0, '0, '0, left, colour);
            end
            default:
            begin
                res_count = 2'd1;
            end
        endcase
        res0.last = (res_count == 2'd1);
        res1.last = 1'b1;
    end

endmodule

[src/tcc_out_buf.sv]
// Two-entry result buffer of the text console cursor engine: holds the
// results of one request and hands them out one transfer per cycle while
// the receiver is ready. Depends on tcc_pkg.
module tcc_out_buf (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             load,
    input  logic [1:0]                       load_count,
    input  tcc_pkg::res_t                    load_res0,
    input  tcc_pkg::res_t                    load_res1,
    output logic                             can_load,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [tcc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,   // command, glyph, pixel_x,
                                                             // pixel_y, colour,
                                                             // cursor_col, cursor_row
    output logic                             m_axis_tlast
);
    import tcc_pkg::*;

    logic [1:0] count_reg;
    logic [1:0] count_next;
    res_t       slot0_reg;
    res_t       slot0_next;
    res_t       slot1_reg;
    res_t       slot1_next;
    logic       pop;

    assign pop      = (count_reg != 2'd0) && m_axis_tready;
    assign can_load = (count_reg == 2'd0) || ((count_reg == 2'd1) && m_axis_tready);

    always_comb
    begin
        count_next = count_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (load)
        begin
            count_next = load_count;
            slot0_next = load_res0;
            slot1_next = load_res1;
        end
        else if (pop)
        begin
            count_next = count_reg - 2'd1;
            slot0_next = slot1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign m_axis_tvalid = (count_reg != 2'd0);
    assign m_axis_tlast  = slot0_reg.last;
    assign m_axis_tdata  = {6'd0, slot0_reg.cursor_row, slot0_reg.cursor_col,
                            slot0_reg.colour, slot0_reg.pixel_y, slot0_reg.pixel_x,
                            slot0_reg.glyph, slot0_reg.command};

endmodule

[src/text_console_cursor_engine.sv]
// Text console cursor engine. A request is taken into an input register and
// resolved against the cursor registers once the output buffer can take its
// results; these go to a two-entry buffer that drains one transfer per cycle
// while the receiver is ready. Requests that give one result (or none, for a
// zero byte) stream at one per clock while the receiver is ready; a request
// at the last cell of the page gives a scroll and a second result, and the
// next request waits until the first has left. Results are registered in the
// buffer. Configuration writes take effect at once and are meant for idle
// periods only. Depends on tcc_pkg, tcc_core and tcc_out_buf.
module text_console_cursor_engine (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [tcc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [tcc_pkg::COLOR_W-1:0]        cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [tcc_pkg::IN_DATA_W-1:0]      s_axis_tdata,   // char_code, move_col,
                                                               // move_row
    input  logic [1:0]                         s_axis_tuser,   // req_type
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [tcc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,   // command, glyph, pixel_x,
                                                               // pixel_y, colour,
                                                               // cursor_col, cursor_row
    output logic                               m_axis_tlast
);
    import tcc_pkg::*;

    cfg_t             cfg_reg;
    req_t             in_req_reg;
    logic             in_valid_reg;
    logic             in_valid_next;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] row_reg;
    logic [COL_W-1:0] col_next;
    logic [COL_W-1:0] row_next;
    logic [1:0]       res_count;
    res_t             res0;
    res_t             res1;
    logic             can_load;
    logic             load;
    logic             accept;

    assign load          = in_valid_reg && can_load;
    assign s_axis_tready = !in_valid_reg || can_load;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_valid_next = accept ? 1'b1 : (load ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.chars_per_line   <= COL_W'(112);
            cfg_reg.chars_per_column <= COL_W'(47);
            cfg_reg.screen_width_px  <= SCR_W'(1024);
            cfg_reg.left_offset_px   <= 8'd4;
            cfg_reg.text_colour      <= 32'hFFFF_FFFF;
            in_valid_reg             <= 1'b0;
            col_reg                  <= '0;
            row_reg                  <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (load)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_CHARS_PER_LINE:   cfg_reg.chars_per_line   <= cfg_wdata[COL_W-1:0];
                    REG_CHARS_PER_COLUMN: cfg_reg.chars_per_column <= cfg_wdata[COL_W-1:0];
                    REG_SCREEN_WIDTH_PX:  cfg_reg.screen_width_px  <= cfg_wdata[SCR_W-1:0];
                    REG_LEFT_OFFSET_PX:   cfg_reg.left_offset_px   <= cfg_wdata[7:0];
                    REG_TEXT_COLOUR:      cfg_reg.text_colour      <= cfg_wdata;
                    default:              cfg_reg                  <= cfg_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_req_reg.req_type  <= s_axis_tuser;
            in_req_reg.char_code <= s_axis_tdata[7:0];
            in_req_reg.move_col  <= s_axis_tdata[17:8];
            in_req_reg.move_row  <= s_axis_tdata[27:18];
        end
    end

    tcc_core u_core (
        .req       (in_req_reg),
        .cfg       (cfg_reg),
        .cur_col   (col_reg),
        .cur_row   (row_reg),
        .res_count (res_count),
        .res0      (res0),
        .res1      (res1),
        .next_col  (col_next),
        .next_row  (row_next)
    );

    tcc_out_buf u_out_buf (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (load),
        .load_count    (res_count),
        .load_res0     (res0),
        .load_res1     (res1),
        .can_load      (can_load),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

[src/tcc_checker.sv]
// Port-level checks for the text console cursor engine, bound to the top
// level. Depends on tcc_pkg and text_console_cursor_engine.
module tcc_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_axis_tready,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [tcc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input logic                               m_axis_tlast
);
    import tcc_pkg::*;

    logic [1:0] cmd;
    assign cmd = m_axis_tdata[1:0];

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output transfer changed while stalled");

    a_clear_home: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && cmd == CMD_CLEAR |->
            m_axis_tdata[89:70] == 20'd0 && m_axis_tlast)
        else $error("clear command without home cursor or last mark");

    a_nondraw_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && cmd != CMD_DRAW |-> m_axis_tdata[69:2] == 68'd0)
        else $error("draw parameters set on a non-draw command");

    a_update_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && cmd == CMD_UPDATE |-> m_axis_tlast)
        else $error("cursor update not the final result");

    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result waiting");

endmodule

bind text_console_cursor_engine tcc_checker u_tcc_checker (.*);

[sim/text_console_cursor_checker.sv]
`timescale 1ns / 100ps
// Checker for the text console cursor engine: follows register writes and
// request transfers, predicts each result transfer and compares it field by field.
// Depends on tcc_pkg for the command codes, register indexes and result type.
module text_console_cursor_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [tcc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [tcc_pkg::COLOR_W-1:0]        cfg_wdata,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    input  logic [tcc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    input  logic [1:0]                         s_axis_tuser,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [tcc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic                               m_axis_tlast,
    output int                                 errors,
    output logic                               busy,
    output int                                 req_count,
    output int                                 res_count,
    output int                                 scroll_count
);

    import tcc_pkg::*;

    logic [COL_W-1:0]   cfg_cpl;
    logic [COL_W-1:0]   cfg_cpc;
    logic [SCR_W-1:0]   cfg_sw;
    logic [7:0]         cfg_off;
    logic [COLOR_W-1:0] cfg_colour;
    logic [COL_W-1:0]   cur_col;
    logic [COL_W-1:0]   cur_row;

    res_t pending_cmds[$];
    res_t step_cmds[$];

    int fail_count = 0;
    int n_req = 0;
    int n_res = 0;
    int n_scroll = 0;

    assign errors       = fail_count;
    assign req_count    = n_req;
    assign res_count    = n_res;
    assign scroll_count = n_scroll;

    function automatic res_t snap(cmd_t cmd, logic [7:0] g);
        res_t r;
        r = '0;
        r.command = cmd;
        if (cmd == CMD_DRAW)
        begin
            r.glyph   = g;
            r.pixel_x = PIX_W'(32'(cur_col) * GLYPH_WIDTH + 32'(cfg_off));
            r.pixel_y = PIX_W'(32'(cur_row) * GLYPH_HEIGHT);
            r.colour  = cfg_colour;
        end
        r.cursor_col = cur_col;
        r.cursor_row = cur_row;
        r.last       = 1'b0;
        return r;
    endfunction

    function automatic logic [COL_W-1:0] sat_inc(logic [COL_W-1:0] v);
        return (v == CUR_MAX) ? v : v + 1'b1;
    endfunction

    function automatic void draw_then(logic [7:0] g, logic [COL_W-1:0] next_col);
        res_t r;
        r = snap(CMD_DRAW, g);
        cur_col = next_col;
        r.cursor_col = next_col;
        step_cmds.push_back(r);
    endfunction

    function automatic void line_feed();
        cur_col = '0;
        if (cur_row < cfg_cpc)
        begin
            cur_row = cur_row + 1'b1;
            step_cmds.push_back(snap(CMD_UPDATE, 8'd0));
        end
        else
        begin
            step_cmds.push_back(snap(CMD_SCROLL, 8'd0));
        end
    endfunction

    function automatic void print_char(logic [7:0] ch);
        logic [31:0] stop;
        if (ch == CHAR_NUL)
            return;
        if (ch == CHAR_CR)
        begin
            cur_col = '0;
            step_cmds.push_back(snap(CMD_UPDATE, 8'd0));
        end
        else if (ch == CHAR_BS)
        begin
            if (cur_col != '0)
            begin
                cur_col = cur_col - 1'b1;
                step_cmds.push_back(snap(CMD_DRAW, CHAR_SPACE));
            end
            else if (cur_row != '0)
            begin
                cur_col = cfg_cpl - 1'b1;
                cur_row = cur_row - 1'b1;
                step_cmds.push_back(snap(CMD_DRAW, CHAR_SPACE));
            end
            else
            begin
                step_cmds.push_back(snap(CMD_UPDATE, 8'd0));
            end
        end
        else if (cur_row == cfg_cpc && cur_col == cfg_cpl)
        begin
            cur_col = '0;
            step_cmds.push_back(snap(CMD_SCROLL, 8'd0));
            if (ch == CHAR_LF || ch == CHAR_TAB)
                step_cmds.push_back(snap(CMD_SCROLL, 8'd0));
            else
                draw_then(ch, 10'd1);
        end
        else if (32'(cfg_sw) >= WRAP_MARGIN_PX &&
                 32'(cur_col) * GLYPH_WIDTH >= 32'(cfg_sw) - WRAP_MARGIN_PX)
        begin
            cur_col = '0;
            cur_row = sat_inc(cur_row);
            draw_then(ch, 10'd1);
        end
        else if (ch == CHAR_LF)
        begin
            line_feed();
        end
        else if (ch == CHAR_TAB)
        begin
            stop = 32'(cur_col) + TAB_STOP;
            stop = stop - stop % TAB_STOP;
            if (stop < 32'(cfg_cpl))
            begin
                cur_col = COL_W'(stop);
                step_cmds.push_back(snap(CMD_UPDATE, 8'd0));
            end
            else
            begin
                line_feed();
            end
        end
        else
        begin
            draw_then(ch, sat_inc(cur_col));
        end
    endfunction

    function automatic void advance_cursor(logic [1:0] rt, logic [7:0] ch,
                                           logic [COL_W-1:0] mc, logic [COL_W-1:0] mr);
        res_t r;
        step_cmds.delete();
        case (rt)
            REQ_PRINT:
                print_char(ch);
            REQ_MOVE:
            begin
                if (mc <= cfg_cpl && mr <= cfg_cpc)
                begin
                    cur_col = mc;
                    cur_row = mr;
                end
                step_cmds.push_back(snap(CMD_UPDATE, 8'd0));
            end
            REQ_CLEAR:
            begin
                cur_col = '0;
                cur_row = '0;
                step_cmds.push_back(snap(CMD_CLEAR, 8'd0));
            end
            default:
                step_cmds.push_back(snap(CMD_UPDATE, 8'd0));
        endcase
        if (step_cmds.size() != 0)
        begin
            r = step_cmds.pop_back();
            r.last = 1'b1;
            step_cmds.push_back(r);
        end
        foreach (step_cmds[i])
            pending_cmds.push_back(step_cmds[i]);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void check_result();
        res_t want;
        if (pending_cmds.size() == 0)
        begin
            $error("result transfer arrived with no prediction waiting");
            fail_count++;
            return;
        end
        want = pending_cmds.pop_front();
        if (want.command == CMD_SCROLL)
            n_scroll++;
        check_field("command", want.command, m_axis_tdata[1:0]);
        check_field("glyph", want.glyph, m_axis_tdata[9:2]);
        check_field("pixel_x", want.pixel_x, m_axis_tdata[23:10]);
        check_field("pixel_y", want.pixel_y, m_axis_tdata[37:24]);
        check_field("colour", want.colour, m_axis_tdata[69:38]);
        check_field("cursor_col", want.cursor_col, m_axis_tdata[79:70]);
        check_field("cursor_row", want.cursor_row, m_axis_tdata[89:80]);
        check_field("last", want.last, m_axis_tlast);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_cpl    = 10'd112;
            cfg_cpc    = 10'd47;
            cfg_sw     = 13'd1024;
            cfg_off    = 8'd4;
            cfg_colour = 32'hFFFF_FFFF;
            cur_col    = '0;
            cur_row    = '0;
            pending_cmds.delete();
            busy <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                n_res++;
                check_result();
            end
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_CHARS_PER_LINE:   cfg_cpl    = cfg_wdata[COL_W-1:0];
                    REG_CHARS_PER_COLUMN: cfg_cpc    = cfg_wdata[COL_W-1:0];
                    REG_SCREEN_WIDTH_PX:  cfg_sw     = cfg_wdata[SCR_W-1:0];
                    REG_LEFT_OFFSET_PX:   cfg_off    = cfg_wdata[7:0];
                    REG_TEXT_COLOUR:      cfg_colour = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                n_req++;
                advance_cursor(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[17:8],
                               s_axis_tdata[27:18]);
            end
            busy <= (pending_cmds.size() != 0);
        end
    end

endmodule

[sim/text_console_cursor_engine_tb.sv]
`timescale 1ns / 100ps
// Top of the cursor engine testbench: clock, reset, register settings, request
// stimulus with bursty sender and stalling receiver, watchdog and final verdict.
// Depends on tcc_pkg, text_console_cursor_engine and text_console_cursor_checker.
module text_console_cursor_engine_tb;

    import tcc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEMS_PER_PHASE = 205;
    localparam logic [1:0] REQ_RESERVED = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [COLOR_W-1:0]    cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    int   errors;
    logic busy;
    int   req_count;
    int   res_count;
    int   scroll_count;

    int idle_cycles = 0;
    int rx_mode = 0;
    int rx_left = 0;
    int burst_left = 0;
    int phase_count = 0;
    int line_max = 112;
    int page_max = 47;

    text_console_cursor_engine u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    text_console_cursor_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .errors        (errors),
        .busy          (busy),
        .req_count     (req_count),
        .res_count     (res_count),
        .scroll_count  (scroll_count)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(8, 64);
        end
        else
        begin
            rx_left--;
        end
        case (rx_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
            2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= ((rx_left % 8) < 3);
        endcase
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no transfer for %0d cycles.", idle_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic push_req(logic [1:0] rt, logic [7:0] ch, logic [COL_W-1:0] mc,
                            logic [COL_W-1:0] mr);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, mr, mc, ch};
        s_axis_tuser  <= rt;
        do
            @(posedge clk);
        while (!s_axis_tready);
        burst_left--;
    endtask

    task automatic move_to(int mc, int mr);
        push_req(REQ_MOVE, 8'($urandom), COL_W'(mc), COL_W'(mr));
    endtask

    task automatic print(logic [7:0] ch);
        push_req(REQ_PRINT, ch, COL_W'($urandom), COL_W'($urandom));
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [COLOR_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
    endtask

    task automatic set_config(int cpl, int cpc, int sw, int off, logic [31:0] colour);
        settle();
        write_reg(REG_CHARS_PER_LINE, cpl);
        write_reg(REG_CHARS_PER_COLUMN, cpc);
        write_reg(REG_SCREEN_WIDTH_PX, sw);
        write_reg(REG_LEFT_OFFSET_PX, off);
        write_reg(REG_TEXT_COLOUR, colour);
        cfg_we <= 1'b0;
        @(posedge clk);
        line_max = cpl;
        page_max = cpc;
        phase_count++;
    endtask

    task automatic random_item();
        int pick;
        int mc;
        logic [7:0] ctl;
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            print(8'($urandom_range(32, 255)));
        end
        else if (pick < 65)
        begin
            case ($urandom_range(0, 4))
                0:       ctl = CHAR_CR;
                1:       ctl = CHAR_BS;
                2:       ctl = CHAR_LF;
                3:       ctl = CHAR_TAB;
                default: ctl = CHAR_NUL;
            endcase
            print(ctl);
        end
        else if (pick < 75)
        begin
            move_to($urandom_range(0, line_max), $urandom_range(0, page_max));
        end
        else if (pick < 83)
        begin
            mc = line_max - $urandom_range(0, (line_max < 2) ? line_max : 2);
            move_to(mc, $urandom_range(0, 1) ? page_max : $urandom_range(0, page_max));
        end
        else if (pick < 86)
        begin
            push_req(REQ_CLEAR, 8'($urandom), COL_W'($urandom), COL_W'($urandom));
        end
        else if (pick < 88)
        begin
            push_req(REQ_RESERVED, 8'($urandom), COL_W'($urandom), COL_W'($urandom));
        end
        else
        begin
            push_req(2'($urandom), 8'($urandom), COL_W'($urandom), COL_W'($urandom));
        end
    endtask

    task automatic random_run();
        repeat (ITEMS_PER_PHASE) random_item();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        phase_count = 1;

        print(CHAR_BS);
        print(CHAR_NUL);
        print("A");
        print(8'hFF);
        print(CHAR_TAB);
        print(CHAR_CR);
        print(CHAR_LF);
        print(CHAR_BS);
        move_to(112, 47);
        print("Z");
        move_to(112, 47);
        print(CHAR_LF);
        move_to(112, 47);
        print(CHAR_TAB);
        move_to(113, 0);
        move_to(1023, 1023);
        push_req(REQ_RESERVED, 8'hFF, '1, '1);
        move_to(112, 0);
        print("x");
        print(CHAR_LF);
        move_to(110, 3);
        print(CHAR_TAB);
        push_req(REQ_CLEAR, 8'h00, '0, '0);
        move_to(0, 47);
        print(CHAR_LF);
        random_run();

        set_config(1023, 1023, 8191, 255, 32'h0000_0000);
        move_to(950, 1023);
        print("q");
        random_run();

        set_config(1, 1, 16, 0, 32'hFFFF_FFFF);
        random_run();

        set_config(0, 20, 5, 7, $urandom);
        move_to(0, 5);
        print(CHAR_BS);
        print("a");
        random_run();

        set_config(0, 0, 9, $urandom_range(0, 255), $urandom);
        random_run();

        set_config(20, 10, 200, $urandom_range(0, 255), $urandom);
        random_run();

        set_config(39, 23, 360, $urandom_range(0, 255), $urandom);
        random_run();

        set_config($urandom_range(1, 1023), $urandom_range(1, 1023), $urandom_range(16, 8191),
                   $urandom_range(0, 255), $urandom);
        random_run();

        set_config(112, 47, 1024, 4, 32'hFFFF_FFFF);
        random_run();

        settle();
        $display("Covered %0d requests and %0d result transfers (%0d scrolls)", req_count,
                 res_count, scroll_count);
        $display("over %0d register settings, with %0d mismatches.", phase_count, errors);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[files.f]
src/tcc_pkg.sv
src/tcc_core.sv
src/tcc_out_buf.sv
src/text_console_cursor_engine.sv
src/tcc_checker.sv
sim/text_console_cursor_checker.sv
sim/text_console_cursor_engine_tb.sv
